[design/ibfc_pkg.sv]
// Shared types and constants for the IMU burst frame checker.
`default_nettype none

package ibfc_pkg;

    localparam int WORD_W   = 16;
    localparam int AXIS_W   = 32;
    localparam int NUM_AXES = 6;

    typedef logic [4:0] t_pos;
    typedef logic [2:0] t_axis_idx;

    localparam t_pos FRAME_WORDS    = 5'd19;
    localparam t_pos POS_DIAG       = 5'd1;
    localparam t_pos POS_AXES_FIRST = 5'd2;
    localparam t_pos POS_TEMP       = 5'd14;
    localparam t_pos POS_COUNTER    = 5'd15;
    localparam t_pos POS_SUM_LAST   = 5'd17;
    localparam t_pos POS_CHECK      = 5'd18;

    typedef enum logic [1:0] {
        ST_GOOD       = 2'd0,
        ST_CKSUM_FAIL = 2'd1,
        ST_DIAG_FAULT = 2'd2,
        ST_STALE      = 2'd3
    } t_status;

    typedef struct packed {
        t_status                    status;
        logic [WORD_W-1:0]          diag_flags;
        logic signed [AXIS_W-1:0]   gyro_x;
        logic signed [AXIS_W-1:0]   gyro_y;
        logic signed [AXIS_W-1:0]   gyro_z;
        logic signed [AXIS_W-1:0]   accel_x;
        logic signed [AXIS_W-1:0]   accel_y;
        logic signed [AXIS_W-1:0]   accel_z;
        logic signed [WORD_W-1:0]   temperature_raw;
        logic [WORD_W-1:0]          sample_count;
    } t_result;

endpackage

`default_nettype wire

[design/ibfc_in_if.sv]
// Input channel: one burst frame word per transfer.
`default_nettype none

interface ibfc_in_if;
    logic        valid;
    logic        ready;
    logic        frame_start;
    logic [15:0] frame_word;

    modport source (output valid, output frame_start, output frame_word, input ready);
    modport sink   (input valid, input frame_start, input frame_word, output ready);
endinterface

`default_nettype wire

[design/ibfc_out_if.sv]
// Output channel: one frame verdict with decoded sample per transfer.
`default_nettype none

interface ibfc_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [15:0]        diag_flags;
    logic signed [31:0] gyro_x;
    logic signed [31:0] gyro_y;
    logic signed [31:0] gyro_z;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
    logic signed [15:0] temperature_raw;
    logic [15:0]        sample_count;

    modport source (
        output valid, output status, output diag_flags,
        output gyro_x, output gyro_y, output gyro_z,
        output accel_x, output accel_y, output accel_z,
        output temperature_raw, output sample_count,
        input  ready
    );
    modport sink (
        input  valid, input status, input diag_flags,
        input  gyro_x, input gyro_y, input gyro_z,
        input  accel_x, input accel_y, input accel_z,
        input  temperature_raw, input sample_count,
        output ready
    );
endinterface

`default_nettype wire

[design/ibfc_in_stage.sv]
// Input register holding one frame word until the frame logic consumes it.
`default_nettype none

module ibfc_in_stage
    import ibfc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    ibfc_in_if.sink                i_in,
    input  wire logic              i_take,
    output logic                   o_valid,
    output logic                   o_start,
    output logic [WORD_W-1:0]      o_word
);

    logic              r_valid;
    logic              r_start;
    logic [WORD_W-1:0] r_word;
    logic              accept;

    assign i_in.ready = !r_valid || i_take;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_start <= i_in.frame_start;
            r_word  <= i_in.frame_word;
        end
    end

    assign o_valid = r_valid;
    assign o_start = r_start;
    assign o_word  = r_word;

endmodule

`default_nettype wire

[design/ibfc_frame_acc.sv]
// Frame position tracking, byte checksum, word capture and verdict.
`default_nettype none

module ibfc_frame_acc
    import ibfc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic              i_start,
    input  wire logic [WORD_W-1:0] i_word,
    input  wire logic              i_out_free,
    output logic                   o_take,
    output logic                   o_res_valid,
    output t_result                o_res
);

    t_pos              r_pos;
    logic [WORD_W-1:0] r_sum;
    logic [WORD_W-1:0] r_last_counter;
    logic [WORD_W-1:0] r_diag;
    logic [WORD_W-1:0] r_temp;
    logic [WORD_W-1:0] r_counter;
    logic [WORD_W-1:0] r_axis_lo [NUM_AXES];
    logic [WORD_W-1:0] r_axis_hi [NUM_AXES];

    t_pos              pos;
    t_pos              n_pos;
    t_pos              rel;
    t_axis_idx         axis_idx;
    logic              is_check;
    logic              in_sum_range;
    logic              is_axis;
    logic [WORD_W-1:0] sum_base;
    logic [WORD_W-1:0] byte_add;
    logic [WORD_W-1:0] n_sum;
    t_status           status;
    logic              good;

    always_comb begin
        pos = i_start ? '0 : r_pos;
        if (pos >= FRAME_WORDS) begin
            pos = '0;
        end
        is_check     = (pos == POS_CHECK);
        in_sum_range = (pos >= POS_AXES_FIRST) && (pos <= POS_SUM_LAST);
        is_axis      = (pos >= POS_AXES_FIRST) && (pos < POS_TEMP);
        rel          = pos - POS_AXES_FIRST;
        axis_idx     = rel[3:1];
        sum_base     = (pos == '0) ? '0 : r_sum;
        byte_add     = {8'd0, i_word[15:8]} + {8'd0, i_word[7:0]};
        n_sum        = in_sum_range ? (sum_base + byte_add) : sum_base;
        n_pos        = is_check ? '0 : (pos + 5'd1);
        o_take       = i_valid && (!is_check || i_out_free);
        o_res_valid  = o_take && is_check;

        if ((n_sum == '0) || (n_sum != i_word)) begin
            status = ST_CKSUM_FAIL;
        end else if (r_diag != '0) begin
            status = ST_DIAG_FAULT;
        end else if (r_counter == r_last_counter) begin
            status = ST_STALE;
        end else begin
            status = ST_GOOD;
        end
        good = (status == ST_GOOD);

        o_res.status          = status;
        o_res.diag_flags      = r_diag;
        o_res.sample_count    = r_counter;
        o_res.gyro_x          = good ? {r_axis_hi[0], r_axis_lo[0]} : '0;
        o_res.gyro_y          = good ? {r_axis_hi[1], r_axis_lo[1]} : '0;
        o_res.gyro_z          = good ? {r_axis_hi[2], r_axis_lo[2]} : '0;
        o_res.accel_x         = good ? {r_axis_hi[3], r_axis_lo[3]} : '0;
        o_res.accel_y         = good ? {r_axis_hi[4], r_axis_lo[4]} : '0;
        o_res.accel_z         = good ? {r_axis_hi[5], r_axis_lo[5]} : '0;
        o_res.temperature_raw = good ? r_temp : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos          <= '0;
            r_sum          <= '0;
            r_last_counter <= '0;
            r_diag         <= '0;
        end else if (o_take) begin
            r_pos <= n_pos;
            r_sum <= n_sum;
            if (pos == POS_DIAG) begin
                r_diag <= i_word;
            end
            if (is_check && good) begin
                r_last_counter <= r_counter;
            end
        end
    end

    // captures, no reset: always written before the checksum word
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            if (is_axis) begin
                if (rel[0]) begin
                    r_axis_hi[axis_idx] <= i_word;
                end else begin
                    r_axis_lo[axis_idx] <= i_word;
                end
            end
            if (pos == POS_TEMP) begin
                r_temp <= i_word;
            end
            if (pos == POS_COUNTER) begin
                r_counter <= i_word;
            end
        end
    end

`ifndef ASSERT_OFF
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_CHECK)
        else $error("frame position beyond checksum word");

    a_pos_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> (r_pos == '0))
        else $error("position not back at word 0 after checksum word");

    a_last_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_last_counter)) |->
            $past(o_res_valid && (o_res.status == ST_GOOD)))
        else $error("last counter moved without a good frame");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && is_check && !i_out_free) |=> $stable(r_pos) && $stable(r_last_counter))
        else $error("frame state moved while verdict stalled");
`endif

endmodule

`default_nettype wire

[design/ibfc_out_stage.sv]
// Result register driving the output channel.
`default_nettype none

module ibfc_out_stage
    import ibfc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_res_valid,
    input  wire t_result i_res,
    output logic         o_free,
    ibfc_out_if.source   o_out
);

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid           = r_valid;
    assign o_out.status          = r_res.status;
    assign o_out.diag_flags      = r_res.diag_flags;
    assign o_out.gyro_x          = r_res.gyro_x;
    assign o_out.gyro_y          = r_res.gyro_y;
    assign o_out.gyro_z          = r_res.gyro_z;
    assign o_out.accel_x         = r_res.accel_x;
    assign o_out.accel_y         = r_res.accel_y;
    assign o_out.accel_z         = r_res.accel_z;
    assign o_out.temperature_raw = r_res.temperature_raw;
    assign o_out.sample_count    = r_res.sample_count;

endmodule

`default_nettype wire

[design/imu_burst_frame_checker_unit.sv]
// Top level of the IMU burst frame checker.
//
// Channel  Dir  Interface    Payload
// i_in     in   ibfc_in_if   frame_start, frame_word
// o_out    out  ibfc_out_if  status, diag_flags, six axes, temperature_raw, sample_count
//
// One frame word is taken every cycle, but the checksum word waits on a stalled
// output; other words keep flowing. The frame logic sits between an input register
// and a result register, so a verdict passes through both registers before it is
// offered on o_out. Synchronous active-low reset clears position, checksum, last
// counter, diagnostic capture and both valid flags.
`default_nettype none

module imu_burst_frame_checker_unit
    import ibfc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ibfc_in_if.sink    i_in,
    ibfc_out_if.source o_out
);

    logic              take;
    logic              word_valid;
    logic              word_start;
    logic [WORD_W-1:0] word;
    logic              out_free;
    logic              res_valid;
    t_result           res;

    ibfc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_valid (word_valid),
        .o_start (word_start),
        .o_word  (word)
    );

    ibfc_frame_acc u_frame_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (word_valid),
        .i_start     (word_start),
        .i_word      (word),
        .i_out_free  (out_free),
        .o_take      (take),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    ibfc_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_free      (out_free),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
